FILE: design/ird_pkg.sv
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the IR pulse-distance decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ird_pkg;

  localparam int FRAME_BITS = 12;
  localparam int TIME_W     = 24;
  localparam int COUNT_W    = $clog2(FRAME_BITS + 1);
  localparam int TICK_W     = 4;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [TIME_W-1:0] START_GAP_RST  = TIME_W'(1600000);
  localparam logic [TIME_W-1:0] ONE_GAP_RST    = TIME_W'(120000);
  localparam logic [TIME_W-1:0] RELOAD_RST     = {TIME_W{1'b1}};
  localparam logic [TICK_W-1:0] HOLD_LIMIT_RST = TICK_W'(3);

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_GAP  = 2'd0,
    REG_ONE_GAP    = 2'd1,
    REG_RELOAD     = 2'd2,
    REG_HOLD_LIMIT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_gap_cycles;
    logic [TIME_W-1:0] one_gap_cycles;
    logic [TIME_W-1:0] counter_reload;
    logic [TICK_W-1:0] hold_tick_limit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/ird_if.sv
// ----------------------------------------------------------------------------
// ird_if
// Valid/ready channels for edge items and decoded code items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ird_edge_if import ird_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [TIME_W-1:0] edge_time;

  modport source (output valid, output cmd, output edge_time, input ready);
  modport sink   (input valid, input cmd, input edge_time, output ready);
endinterface

interface ird_code_if import ird_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FRAME_BITS-1:0] code;

  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

`default_nettype wire

FILE: design/ird_cfg.sv
// ----------------------------------------------------------------------------
// ird_cfg
// APB register file holding the decoder thresholds and limits.
// ----------------------------------------------------------------------------
`default_nettype none

module ird_cfg import ird_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_gap_cycles <= START_GAP_RST;
      cfg.one_gap_cycles   <= ONE_GAP_RST;
      cfg.counter_reload   <= RELOAD_RST;
      cfg.hold_tick_limit  <= HOLD_LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_GAP:  cfg.start_gap_cycles <= pwdata[TIME_W-1:0];
        REG_ONE_GAP:    cfg.one_gap_cycles   <= pwdata[TIME_W-1:0];
        REG_RELOAD:     cfg.counter_reload   <= pwdata[TIME_W-1:0];
        REG_HOLD_LIMIT: cfg.hold_tick_limit  <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_GAP:  prdata = DATA_W'(cfg.start_gap_cycles);
      REG_ONE_GAP:    prdata = DATA_W'(cfg.one_gap_cycles);
      REG_RELOAD:     prdata = DATA_W'(cfg.counter_reload);
      REG_HOLD_LIMIT: prdata = DATA_W'(cfg.hold_tick_limit);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ird_core.sv
// ----------------------------------------------------------------------------
// ird_core
// Input register, gap and frame decode, repeat filter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ird_core import ird_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  ird_edge_if.sink        edges,
  ird_code_if.source      codes
);

  // input register
  logic              in_valid;
  logic              in_cmd;
  logic [TIME_W-1:0] in_time;

  // decoder state
  logic [TIME_W-1:0]     prev_edge_time, prev_edge_time_next;
  logic                  edge_seen, edge_seen_next;
  logic [COUNT_W-1:0]    bit_count, bit_count_next;
  logic [FRAME_BITS-1:0] frame_bits, frame_bits_next;
  logic [FRAME_BITS-1:0] prev_code, prev_code_next;
  logic                  prev_code_valid, prev_code_valid_next;
  logic [TICK_W-1:0]     wrap_ticks, wrap_ticks_next;

  // result register
  logic                  res_valid;
  logic [FRAME_BITS-1:0] res_code;

  logic          advance;
  logic          emit;
  logic          bit_val;
  logic          held;
  logic [TIME_W:0] span;
  logic [TIME_W:0] gap;

  assign advance     = !res_valid || codes.ready;
  assign edges.ready = !in_valid || advance;
  assign codes.valid = res_valid;
  assign codes.code  = res_code;

  always_comb begin
    span = {1'b0, prev_edge_time} + {1'b0, cfg.counter_reload} + (TIME_W+1)'(1);
    if (prev_edge_time >= in_time) begin
      gap = {1'b0, prev_edge_time - in_time};
    end else if (span < {1'b0, in_time}) begin
      gap = '0;
    end else begin
      gap = span - {1'b0, in_time};
    end
  end

  always_comb begin
    prev_edge_time_next  = prev_edge_time;
    edge_seen_next       = edge_seen;
    bit_count_next       = bit_count;
    frame_bits_next      = frame_bits;
    prev_code_next       = prev_code;
    prev_code_valid_next = prev_code_valid;
    wrap_ticks_next      = wrap_ticks;
    emit                 = 1'b0;
    held                 = 1'b0;
    bit_val              = gap > {1'b0, cfg.one_gap_cycles};

    if (in_cmd == CMD_TICK) begin
      if (wrap_ticks != TICK_MAX) begin
        wrap_ticks_next = wrap_ticks + TICK_W'(1);
      end
    end else if (!edge_seen) begin
      edge_seen_next      = 1'b1;
      prev_edge_time_next = in_time;
    end else begin
      prev_edge_time_next = in_time;
      if (gap == '0) begin
        // ignored edge
      end else if (gap > {1'b0, cfg.start_gap_cycles}) begin
        bit_count_next = '0;
      end else if (bit_count >= COUNT_W'(FRAME_BITS)) begin
        bit_count_next = '0;
      end else begin
        for (int i = 0; i < FRAME_BITS; i++) begin
          if (bit_count == COUNT_W'(i)) begin
            frame_bits_next[i] = bit_val;
          end
        end
        bit_count_next = bit_count + COUNT_W'(1);
        if (bit_count_next == COUNT_W'(FRAME_BITS)) begin
          held = prev_code_valid && (frame_bits_next == prev_code) &&
                 (wrap_ticks < cfg.hold_tick_limit);
          wrap_ticks_next = '0;
          if (!held) begin
            prev_code_next       = frame_bits_next;
            prev_code_valid_next = 1'b1;
            emit                 = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      res_valid       <= 1'b0;
      prev_edge_time  <= '0;
      edge_seen       <= 1'b0;
      bit_count       <= '0;
      frame_bits      <= '0;
      prev_code       <= '0;
      prev_code_valid <= 1'b0;
      wrap_ticks      <= '0;
    end else begin
      if (edges.ready) begin
        in_valid <= edges.valid;
      end
      if (advance) begin
        res_valid <= in_valid && emit;
      end
      if (in_valid && advance) begin
        prev_edge_time  <= prev_edge_time_next;
        edge_seen       <= edge_seen_next;
        bit_count       <= bit_count_next;
        frame_bits      <= frame_bits_next;
        prev_code       <= prev_code_next;
        prev_code_valid <= prev_code_valid_next;
        wrap_ticks      <= wrap_ticks_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (edges.ready && edges.valid) begin
      in_cmd  <= edges.cmd;
      in_time <= edges.edge_time;
    end
    if (in_valid && advance && emit) begin
      res_code <= frame_bits_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ir_pulse_distance_decoder.sv
// The code item passes through the input register and then the result
// register. Throughput: one item per cycle unless the code output stalls;
// the input register and the result register let a new item enter while
// a finished code waits to be taken.
// Reset clears decoder state and pending items; registers return to their
// documented defaults.
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// Decodes 12-bit IR remote codes from falling-edge timestamps.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_decoder import ird_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  ird_edge_if.sink               edges,
  ird_code_if.source             codes,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t cfg;

  ird_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ird_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .edges (edges),
    .codes (codes)
  );

endmodule

`default_nettype wire
